// ----- design/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by chunked_send_with_retry_top
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Property must hold at every rising edge out of reset
`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// Expression must never be true out of reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif

`endif

// ----- design/cswr_pkg.sv -----
// ---------------------------------------------------------------------------
// cswr_pkg
// Types and constants of the chunked send controller.
// ---------------------------------------------------------------------------
`default_nettype none

package cswr_pkg;

    localparam int SIZE_BITS    = 12;
    localparam int LEN_BITS     = 8;
    localparam int PORT_BITS    = 8;
    localparam int CNT_BITS     = 8;
    localparam int STATUS_BITS  = 3;
    localparam int APB_ADDR_W   = 4;
    localparam int APB_DATA_W   = 32;

    // errors tolerated before the chunk size starts to shrink
    localparam logic [CNT_BITS-1:0] ERR_SHRINK_AFTER = CNT_BITS'(2);
    localparam logic [CNT_BITS-1:0] CNT_MAX          = '1;

    typedef enum logic {
        OP_START   = 1'b0,
        OP_OUTCOME = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        OUT_SUCCESS = 2'd0,
        OUT_BUSY    = 2'd1,
        OUT_ERROR   = 2'd2
    } outcome_t;

    typedef enum logic {
        KIND_CHUNK = 1'b0,
        KIND_DONE  = 1'b1
    } kind_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_TOO_BIG   = 3'd1,
        ST_SIZE_UNDT = 3'd2,
        ST_BUSY_EXC  = 3'd3,
        ST_IDLE      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        REG_MAX_FRAME   = 2'd0,
        REG_MAX_PAYLOAD = 2'd1,
        REG_SIZE_STEP   = 2'd2,
        REG_BUSY_LIMIT  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        kind_t                  kind;
        logic [SIZE_BITS-1:0]   chunk_offset;
        logic [LEN_BITS-1:0]    chunk_length;
        logic [PORT_BITS-1:0]   port_out;
        status_t                status;
        logic                   last;
    } result_t;

endpackage

`default_nettype wire

// ----- design/cswr_in_if.sv -----
// ---------------------------------------------------------------------------
// cswr_in_if
// Request channel: start and outcome items with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface cswr_in_if
    import cswr_pkg::*;
    ;
    logic                   valid;
    logic                   ready;
    logic                   opcode;
    logic [SIZE_BITS-1:0]   total_size;
    logic [PORT_BITS-1:0]   port;
    logic [1:0]             outcome;

    modport source (output valid, opcode, total_size, port, outcome, input ready);
    modport sink   (input valid, opcode, total_size, port, outcome, output ready);
endinterface

`default_nettype wire

// ----- design/cswr_out_if.sv -----
// ---------------------------------------------------------------------------
// cswr_out_if
// Result channel: chunk requests and finished reports with valid/ready.
// ---------------------------------------------------------------------------
`default_nettype none

interface cswr_out_if
    import cswr_pkg::*;
    ;
    logic                   valid;
    logic                   ready;
    logic                   kind;
    logic [SIZE_BITS-1:0]   chunk_offset;
    logic [LEN_BITS-1:0]    chunk_length;
    logic [PORT_BITS-1:0]   port_out;
    logic [STATUS_BITS-1:0] status;
    logic                   last;

    modport source (output valid, kind, chunk_offset, chunk_length, port_out, status, last,
                    input ready);
    modport sink   (input valid, kind, chunk_offset, chunk_length, port_out, status, last,
                    output ready);
endinterface

`default_nettype wire

// ----- design/chunked_send_with_retry_top.sv -----
// ---------------------------------------------------------------------------
// chunked_send_with_retry_top - segmentation controller with retry
// An accepted item's result appears in the output register in the next cycle.
// Throughput: one item per cycle while the output is not stalled; the output register is the only stage.
// Reset: rst_n clears the transfer state and output valid; the configuration
// registers return to 1024 / 222 / 10 / 3.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module chunked_send_with_retry_top
    import cswr_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    cswr_in_if.sink                     in_item,
    cswr_out_if.source                  out_item,
    input  wire logic                   psel,
    input  wire logic                   penable,
    input  wire logic                   pwrite,
    input  wire logic [APB_ADDR_W-1:0]  paddr,
    input  wire logic [APB_DATA_W-1:0]  pwdata,
    output logic [APB_DATA_W-1:0]       prdata,
    output logic                        pready
);

    // configuration
    logic [SIZE_BITS-1:0]   max_frame_size_reg;
    logic [LEN_BITS-1:0]    max_payload_reg;
    logic [LEN_BITS-1:0]    size_step_reg;
    logic [CNT_BITS-1:0]    busy_limit_reg;

    // transfer state
    logic                   active_reg,         active_next;
    logic [SIZE_BITS-1:0]   frame_size_reg,     frame_size_next;
    logic [SIZE_BITS-1:0]   sent_offset_reg,    sent_offset_next;
    logic [SIZE_BITS-1:0]   bytes_left_reg,     bytes_left_next;
    logic [LEN_BITS-1:0]    payload_size_reg,   payload_size_next;
    logic [CNT_BITS-1:0]    busy_count_reg,     busy_count_next;
    logic [CNT_BITS-1:0]    error_count_reg,    error_count_next;
    logic [PORT_BITS-1:0]   frame_port_reg,     frame_port_next;
    logic [LEN_BITS-1:0]    current_length_reg, current_length_next;

    logic                   out_valid_reg;
    result_t                result_reg,         result_next;

    logic                   in_fire;
    logic                   cfg_write;
    reg_idx_t               cfg_idx;

    // working values
    logic                   emit_chunk;
    logic [SIZE_BITS-1:0]   len_ext;
    logic [CNT_BITS-1:0]    busy_inc;
    logic [CNT_BITS-1:0]    err_inc;
    logic [LEN_BITS-1:0]    shrunk;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frame_size_reg <= SIZE_BITS'(1024);
            max_payload_reg    <= LEN_BITS'(222);
            size_step_reg      <= LEN_BITS'(10);
            busy_limit_reg     <= CNT_BITS'(3);
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_MAX_FRAME:   max_frame_size_reg <= pwdata[SIZE_BITS-1:0];
                REG_MAX_PAYLOAD: max_payload_reg    <= pwdata[LEN_BITS-1:0];
                REG_SIZE_STEP:   size_step_reg      <= pwdata[LEN_BITS-1:0];
                REG_BUSY_LIMIT:  busy_limit_reg     <= pwdata[CNT_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_MAX_FRAME:   prdata = APB_DATA_W'(max_frame_size_reg);
            REG_MAX_PAYLOAD: prdata = APB_DATA_W'(max_payload_reg);
            REG_SIZE_STEP:   prdata = APB_DATA_W'(size_step_reg);
            REG_BUSY_LIMIT:  prdata = APB_DATA_W'(busy_limit_reg);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Item processing
    // ------------------------------------------------------------------
    assign in_item.ready = !out_valid_reg || out_item.ready;
    assign in_fire       = in_item.valid && in_item.ready;

    assign len_ext  = SIZE_BITS'(current_length_reg);
    assign busy_inc = (busy_count_reg != CNT_MAX) ? busy_count_reg + 1'b1 : busy_count_reg;
    assign err_inc  = (error_count_reg != CNT_MAX) ? error_count_reg + 1'b1 : error_count_reg;
    assign shrunk   = (payload_size_reg >= size_step_reg) ?
                      payload_size_reg - size_step_reg : '0;

    always_comb
    begin
        active_next         = active_reg;
        frame_size_next     = frame_size_reg;
        sent_offset_next    = sent_offset_reg;
        bytes_left_next     = bytes_left_reg;
        payload_size_next   = payload_size_reg;
        busy_count_next     = busy_count_reg;
        error_count_next    = error_count_reg;
        frame_port_next     = frame_port_reg;
        current_length_next = current_length_reg;
        emit_chunk          = 1'b0;

        result_next              = '0;
        result_next.kind         = KIND_DONE;
        result_next.status       = ST_OK;
        result_next.last         = 1'b1;

        case (opcode_t'(in_item.opcode))
            OP_START:
            begin
                active_next = 1'b0;
                if (in_item.total_size > max_frame_size_reg)
                begin
                    result_next.status = ST_TOO_BIG;
                end
                else if (in_item.total_size != '0)
                begin
                    frame_size_next   = in_item.total_size;
                    sent_offset_next  = '0;
                    bytes_left_next   = in_item.total_size;
                    frame_port_next   = in_item.port;
                    payload_size_next = (SIZE_BITS'(max_payload_reg) < in_item.total_size) ?
                                        max_payload_reg : in_item.total_size[LEN_BITS-1:0];
                    busy_count_next   = '0;
                    error_count_next  = '0;
                    active_next       = 1'b1;
                    emit_chunk        = 1'b1;
                end
            end
            default:
            begin
                if (!active_reg)
                begin
                    result_next.status = ST_IDLE;
                    result_next.last   = 1'b0;
                end
                else
                begin
                    case (outcome_t'(in_item.outcome))
                        OUT_SUCCESS:
                        begin
                            busy_count_next  = '0;
                            sent_offset_next = sent_offset_reg + len_ext;
                            bytes_left_next  = (bytes_left_reg >= len_ext) ?
                                               bytes_left_reg - len_ext : '0;
                            if (sent_offset_next >= frame_size_reg || bytes_left_next == '0)
                                active_next = 1'b0;
                            else
                                emit_chunk = 1'b1;
                        end
                        OUT_BUSY:
                        begin
                            busy_count_next = busy_inc;
                            if (busy_inc > busy_limit_reg)
                            begin
                                active_next        = 1'b0;
                                result_next.status = ST_BUSY_EXC;
                            end
                            else
                                emit_chunk = 1'b1;
                        end
                        default:
                        begin
                            // error and the unused code: shrink after repeated errors
                            error_count_next = err_inc;
                            if (err_inc > ERR_SHRINK_AFTER)
                                payload_size_next = shrunk;
                            if (err_inc > ERR_SHRINK_AFTER && shrunk < size_step_reg)
                            begin
                                active_next        = 1'b0;
                                result_next.status = ST_SIZE_UNDT;
                            end
                            else if (busy_count_reg > busy_limit_reg)
                            begin
                                active_next        = 1'b0;
                                result_next.status = ST_BUSY_EXC;
                            end
                            else
                                emit_chunk = 1'b1;
                        end
                    endcase
                end
            end
        endcase

        if (emit_chunk)
        begin
            current_length_next      = (SIZE_BITS'(payload_size_next) < bytes_left_next) ?
                                       payload_size_next : bytes_left_next[LEN_BITS-1:0];
            result_next.kind         = KIND_CHUNK;
            result_next.chunk_offset = sent_offset_next;
            result_next.chunk_length = current_length_next;
            result_next.port_out     = frame_port_next;
            result_next.status       = ST_OK;
            result_next.last         = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg         <= 1'b0;
            frame_size_reg     <= '0;
            sent_offset_reg    <= '0;
            bytes_left_reg     <= '0;
            payload_size_reg   <= '0;
            busy_count_reg     <= '0;
            error_count_reg    <= '0;
            frame_port_reg     <= '0;
            current_length_reg <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                active_reg         <= active_next;
                frame_size_reg     <= frame_size_next;
                sent_offset_reg    <= sent_offset_next;
                bytes_left_reg     <= bytes_left_next;
                payload_size_reg   <= payload_size_next;
                busy_count_reg     <= busy_count_next;
                error_count_reg    <= error_count_next;
                frame_port_reg     <= frame_port_next;
                current_length_reg <= current_length_next;
                out_valid_reg      <= 1'b1;
            end
            else if (out_item.ready)
            begin
                // drop the item once taken
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload holds while stalled
    always_ff @(posedge clk)
    begin
        if (in_fire)
            result_reg <= result_next;
    end

    assign out_item.valid        = out_valid_reg;
    assign out_item.kind         = result_reg.kind;
    assign out_item.chunk_offset = result_reg.chunk_offset;
    assign out_item.chunk_length = result_reg.chunk_length;
    assign out_item.port_out     = result_reg.port_out;
    assign out_item.status       = result_reg.status;
    assign out_item.last         = result_reg.last;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `ASSERT_PROP(a_fire_loads_output, clk, rst_n, in_fire |=> out_valid_reg)
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, out_valid_reg && !out_item.ready && in_item.ready)
    `ASSERT_PROP(a_active_has_frame, clk, rst_n, active_reg |-> frame_size_reg != '0)
    `ASSERT_PROP(a_chunk_keeps_active, clk, rst_n,
                 (in_fire && result_next.kind == KIND_CHUNK) |=> active_reg)

endmodule

`default_nettype wire
